// ===== hdl/pasd_pkg.sv =====
package pasd_pkg;

    localparam int SAMPLES     = 8;
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
    localparam int POT_W       = 12;
    localparam int SPEED_W     = 7;
    localparam int STEP_W      = $clog2(SPEED_W);
    localparam int IDX_W       = 1;

    localparam logic [IDX_W-1:0]   REG_POT_MIN = 1'b0;
    localparam logic [IDX_W-1:0]   REG_POT_MAX = 1'b1;
    localparam logic [POT_W-1:0]   POT_MIN_RST = 12'd0;
    localparam logic [POT_W-1:0]   POT_MAX_RST = 12'd4095;
    localparam logic [SPEED_W-1:0] SPEED_FULL  = 7'd127;
    localparam logic [SPEED_W-1:0] SPEED_BAND  = 7'd2;

    typedef struct packed {
        logic acc_en;
        logic clear_sum;
        logic clamp_en;
        logic div_step;
        logic load_out;
    } pasd_cmd_t;

    typedef struct packed {
        logic changed;
    } pasd_sts_t;

endpackage

// ===== hdl/pasd_dp.sv =====
module pasd_dp
    import pasd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [POT_W-1:0]       cfg_data,
    input  logic [POT_W-1:0]       sample,
    input  pasd_cmd_t              cmd,
    output pasd_sts_t              sts,
    output logic [SPEED_W-1:0]     speed
);

    logic [POT_W-1:0]   min_reg, max_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [POT_W-1:0]   range_reg;
    logic [POT_W-1:0]   rem_reg;
    logic [SPEED_W-1:0] quo_reg;
    logic               zero_reg;
    logic [SPEED_W-1:0] last_reg;
    logic [SPEED_W-1:0] speed_reg;

    logic [POT_W-1:0]   avg;
    logic [POT_W-1:0]   range_c;
    logic [POT_W-1:0]   v_c;
    logic [POT_W:0]     shifted;
    logic [POT_W:0]     trial;
    logic [SPEED_W-1:0] result;
    logic [SPEED_W-1:0] diff;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= POT_MIN_RST;
            max_reg <= POT_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POT_MIN: min_reg <= cfg_data;
                REG_POT_MAX: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.clear_sum)
            sum_next = '0;
        else if (cmd.acc_en)
            sum_next = sum_reg + SUM_W'(sample[SAMPLE_BITS-1:0]);
    end

    // average and clamp
    assign avg     = POT_W'(sum_reg / SAMPLES);
    assign range_c = max_reg - min_reg;

    always_comb
    begin
        priority if (avg < min_reg)
            v_c = '0;
        else if (avg >= max_reg)
            v_c = range_c - POT_W'(1);
        else
            v_c = avg - min_reg;
    end

    // restoring division step
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, range_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            last_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (cmd.load_out)
                last_reg <= result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clamp_en)
        begin
            range_reg <= range_c;
            rem_reg   <= v_c;
            quo_reg   <= '0;
            zero_reg  <= (max_reg <= min_reg);
        end
        else if (cmd.div_step)
        begin
            if (!trial[POT_W])
            begin
                rem_reg <= trial[POT_W-1:0];
                quo_reg <= {quo_reg[SPEED_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[POT_W-1:0];
                quo_reg <= {quo_reg[SPEED_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
            speed_reg <= result;
    end

    // dead-band change rule
    assign result = zero_reg ? '0 : quo_reg;
    assign diff   = (result > last_reg) ? (result - last_reg) : (last_reg - result);

    assign sts.changed = (result != last_reg)
                         && ((result == '0) || (result >= SPEED_FULL) || (diff > SPEED_BAND));
    assign speed = speed_reg;

endmodule

// ===== hdl/pasd_ctrl.sv =====
module pasd_ctrl
    import pasd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  pasd_sts_t sts,
    output pasd_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLAMP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic               in_xfer;
    logic               out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd.acc_en = 1'b1;
                    if (count_reg == COUNT_W'(SAMPLES - 1))
                    begin
                        count_next = '0;
                        state_next = ST_CLAMP;
                    end
                    else
                        count_next = count_reg + COUNT_W'(1);
                end
            end
            ST_CLAMP:
            begin
                cmd.clamp_en  = 1'b1;
                cmd.clear_sum = 1'b1;
                step_next     = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SPEED_W - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (sts.changed)
                    begin
                        cmd.load_out   = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/pot_average_scale_deadband_top.sv =====
// a sample transfer is taken while the block is idle; mid-block samples only accumulate
// the last sample of each block of 8 adds a clamp state, 7 divider steps and an emit state
// input is held off through the clamp state, the 7-step restoring divider and the emit state
// rst_n clears the sum, sample count, last speed and output valid; pot_min 0, pot_max 4095
module pot_average_scale_deadband_top
    import pasd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [POT_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [POT_W-1:0]   sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SPEED_W-1:0] speed
);

    pasd_cmd_t cmd;
    pasd_sts_t sts;

    pasd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pasd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .sts       (sts),
        .speed     (speed)
    );

endmodule
